>>> src/json_path_record_escaper_core_defines.svh
// Assertion macros shared by the escaper's modules.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef JSON_PATH_RECORD_ESCAPER_CORE_DEFINES_SVH
`define JSON_PATH_RECORD_ESCAPER_CORE_DEFINES_SVH

`ifndef SYNTH

// The consequent holds in the same cycle as the antecedent.
`define JPRE_ASSERT_IMPLY(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jpre assertion failed");

// The consequent holds in the cycle after the antecedent.
`define JPRE_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jpre assertion failed");

// The expression is never true.
`define JPRE_ASSERT_NEVER(name, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("jpre assertion failed");

`else

`define JPRE_ASSERT_IMPLY(name, ante, cons)
`define JPRE_ASSERT_NEXT(name, ante, cons)
`define JPRE_ASSERT_NEVER(name, expr)

`endif

`endif

>>> src/jpre_pkg.sv
package jpre_pkg;

    // Output position counter: up to 18 bytes per input beat.
    localparam int WORST_BYTES = 18;
    localparam int POS_W       = 5;

    localparam int PREFIX_LEN = 9;
    localparam int SHORT_LEN  = 2;
    localparam int HEX_LEN    = 6;
    localparam int SUFFIX_LEN = 2;

    // Configuration register indexes.
    localparam logic CFG_IDX_JSON_MODE = 1'b0;
    localparam logic CFG_IDX_NUL_TERM  = 1'b1;

    // Characters used in the record framing and escapes.
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_BS        = 8'h08;
    localparam logic [7:0] CH_FF        = 8'h0C;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_LOWER_B   = 8'h62;
    localparam logic [7:0] CH_LOWER_F   = 8'h66;
    localparam logic [7:0] CH_LOWER_N   = 8'h6E;
    localparam logic [7:0] CH_LOWER_R   = 8'h72;
    localparam logic [7:0] CH_LOWER_T   = 8'h74;
    localparam logic [7:0] CH_LOWER_U   = 8'h75;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;

    // Form of the escaped path byte.
    typedef enum logic [2:0] {
        BODY_PLAIN = 3'b001,
        BODY_SHORT = 3'b010,
        BODY_HEX   = 3'b100
    } body_kind_t;

    // Live configuration.
    typedef struct packed {
        logic json_mode;
        logic nul_terminator;
    } jpre_cfg_t;

    // Decoded input beat with its segment boundaries in output positions.
    typedef struct packed {
        logic [7:0]       ch;
        logic [7:0]       esc_char;
        body_kind_t       kind;
        logic [POS_W-1:0] prefix_end;
        logic [POS_W-1:0] body_end;
        logic [POS_W-1:0] suffix_end;
        logic [POS_W-1:0] last_pos;
        logic             nul;
    } jpre_item_t;

    // Sequencer slot handed to the byte generator.
    typedef struct packed {
        logic             valid;
        logic [POS_W-1:0] pos;
        jpre_item_t       item;
    } jpre_slot_t;

    // Second character of a two-byte escape, or zero when there is none.
    function automatic logic [7:0] short_escape(input logic [7:0] ch);
        logic [7:0] esc;
        begin
            case (ch)
                CH_QUOTE:     esc = CH_QUOTE;
                CH_BACKSLASH: esc = CH_BACKSLASH;
                CH_BS:        esc = CH_LOWER_B;
                CH_FF:        esc = CH_LOWER_F;
                CH_LF:        esc = CH_LOWER_N;
                CH_CR:        esc = CH_LOWER_R;
                CH_TAB:       esc = CH_LOWER_T;
                default:      esc = CH_NUL;
            endcase
            return esc;
        end
    endfunction

    // Lowercase hex digit.
    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        begin
            if (nib < 4'd10)
            begin
                return 8'(CH_ZERO + {4'd0, nib});
            end
            return 8'(8'h57 + {4'd0, nib});
        end
    endfunction

    // Object prefix {"path":" by position.
    function automatic logic [7:0] prefix_byte(input logic [3:0] idx);
        logic [7:0] b;
        begin
            case (idx)
                4'd0:    b = 8'h7B;
                4'd1:    b = CH_QUOTE;
                4'd2:    b = 8'h70;
                4'd3:    b = 8'h61;
                4'd4:    b = 8'h74;
                4'd5:    b = 8'h68;
                4'd6:    b = CH_QUOTE;
                4'd7:    b = 8'h3A;
                4'd8:    b = CH_QUOTE;
                default: b = CH_NUL;
            endcase
            return b;
        end
    endfunction

endpackage

>>> src/jpre_cfg_regs.sv
module jpre_cfg_regs (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic               cfg_data,
    output jpre_pkg::jpre_cfg_t cfg
);
    import jpre_pkg::*;

    logic json_mode_reg;
    logic json_mode_next;
    logic nul_term_reg;
    logic nul_term_next;

    // Writes are always taken.
    assign cfg_ready = 1'b1;

    // Register write decode.
    always_comb
    begin
        json_mode_next = json_mode_reg;
        nul_term_next  = nul_term_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_IDX_JSON_MODE: json_mode_next = cfg_data;
                CFG_IDX_NUL_TERM:  nul_term_next  = cfg_data;
                default:           json_mode_next = json_mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            json_mode_reg <= 1'b0;
            nul_term_reg  <= 1'b0;
        end
        else
        begin
            json_mode_reg <= json_mode_next;
            nul_term_reg  <= nul_term_next;
        end
    end

    assign cfg.json_mode      = json_mode_reg;
    assign cfg.nul_terminator = nul_term_reg;

endmodule

>>> src/jpre_sequencer.sv
`include "json_path_record_escaper_core_defines.svh"

module jpre_sequencer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [7:0]          path_byte,
    input  logic                first_of_path,
    input  logic                last_of_path,
    input  jpre_pkg::jpre_cfg_t cfg,
    output jpre_pkg::jpre_slot_t slot
);
    import jpre_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    jpre_item_t       item_reg;
    jpre_item_t       item_next;
    jpre_item_t       decoded;
    logic [POS_W-1:0] body_len;
    logic [7:0]       esc;
    logic             done;
    logic             accept;

    // Classify the incoming byte and place the segment boundaries.
    always_comb
    begin
        esc                = short_escape(path_byte);
        decoded.ch         = path_byte;
        decoded.esc_char   = esc;
        decoded.nul        = cfg.nul_terminator;
        decoded.kind       = BODY_PLAIN;
        body_len           = POS_W'(1);
        decoded.prefix_end = '0;
        if (cfg.json_mode)
        begin
            if (first_of_path)
            begin
                decoded.prefix_end = POS_W'(PREFIX_LEN);
            end
            if (esc != CH_NUL)
            begin
                decoded.kind = BODY_SHORT;
                body_len     = POS_W'(SHORT_LEN);
            end
            else if (path_byte < CH_SPACE)
            begin
                decoded.kind = BODY_HEX;
                body_len     = POS_W'(HEX_LEN);
            end
        end
        decoded.body_end   = POS_W'(decoded.prefix_end + body_len);
        decoded.suffix_end = (cfg.json_mode && last_of_path)
                           ? POS_W'(decoded.body_end + POS_W'(SUFFIX_LEN))
                           : decoded.body_end;
        decoded.last_pos   = POS_W'(decoded.suffix_end + {{(POS_W-1){1'b0}}, last_of_path}
                                    - POS_W'(1));
    end

    // The slot frees itself on the cycle that emits its final byte.
    assign done   = valid_reg && (pos_reg == item_reg.last_pos);
    assign busy   = valid_reg && !done;
    assign accept = start && !busy;

    always_comb
    begin
        valid_next = valid_reg;
        pos_next   = pos_reg;
        item_next  = item_reg;
        if (accept)
        begin
            valid_next = 1'b1;
            pos_next   = '0;
            item_next  = decoded;
        end
        else if (done)
        begin
            valid_next = 1'b0;
        end
        else if (valid_reg)
        begin
            pos_next = POS_W'(pos_reg + POS_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pos_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            pos_reg   <= pos_next;
        end
    end

    // Item payload needs no reset.
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign slot.valid = valid_reg;
    assign slot.pos   = pos_reg;
    assign slot.item  = item_reg;

    // The counter never runs past the item's final byte.
    `JPRE_ASSERT_IMPLY(a_pos_in_item, valid_reg, pos_reg <= item_reg.last_pos)
    // A part-done item advances by exactly one byte each cycle.
    `JPRE_ASSERT_NEXT(a_pos_step, busy, valid_reg && (pos_reg == $past(pos_reg) + POS_W'(1)))
    // No item ever needs more bytes than the worst case.
    `JPRE_ASSERT_NEVER(a_pos_bound, valid_reg && (pos_reg >= POS_W'(WORST_BYTES)))

endmodule

>>> src/jpre_byte_gen.sv
`include "json_path_record_escaper_core_defines.svh"

module jpre_byte_gen (
    input  logic                 clk,
    input  logic                 rst_n,
    input  jpre_pkg::jpre_slot_t slot,
    output logic                 out_strobe,
    output logic [7:0]           out_byte,
    output logic                 record_end,
    output logic                 run_last
);
    import jpre_pkg::*;

    logic             strobe_reg;
    logic [7:0]       byte_reg;
    logic [7:0]       byte_next;
    logic             end_reg;
    logic             end_next;
    logic             last_reg;
    logic             last_next;
    logic [POS_W-1:0] body_off;

    assign body_off = POS_W'(slot.pos - slot.item.prefix_end);

    // Pick the byte for the current position from its segment.
    always_comb
    begin
        end_next  = 1'b0;
        last_next = (slot.pos == slot.item.last_pos);
        byte_next = slot.item.ch;
        if (slot.pos < slot.item.prefix_end)
        begin
            byte_next = prefix_byte(slot.pos[3:0]);
        end
        else if (slot.pos < slot.item.body_end)
        begin
            case (slot.item.kind)
                BODY_PLAIN:
                begin
                    byte_next = slot.item.ch;
                end
                BODY_SHORT:
                begin
                    byte_next = (body_off[2:0] == 3'd0) ? CH_BACKSLASH : slot.item.esc_char;
                end
                BODY_HEX:
                begin
                    case (body_off[2:0])
                        3'd0:    byte_next = CH_BACKSLASH;
                        3'd1:    byte_next = CH_LOWER_U;
                        3'd2:    byte_next = CH_ZERO;
                        3'd3:    byte_next = CH_ZERO;
                        3'd4:    byte_next = hex_digit(slot.item.ch[7:4]);
                        default: byte_next = hex_digit(slot.item.ch[3:0]);
                    endcase
                end
                default:
                begin
                    byte_next = slot.item.ch;
                end
            endcase
        end
        else if (slot.pos < slot.item.suffix_end)
        begin
            byte_next = (slot.pos == slot.item.body_end) ? CH_QUOTE : CH_RBRACE;
        end
        else
        begin
            byte_next = slot.item.nul ? CH_NUL : CH_LF;
            end_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= slot.valid;
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        end_reg  <= end_next;
        last_reg <= last_next;
    end

    assign out_strobe = strobe_reg;
    assign out_byte   = byte_reg;
    assign record_end = end_reg;
    assign run_last   = last_reg;

    // A terminator is always the final byte of its input beat.
    `JPRE_ASSERT_IMPLY(a_end_is_last, strobe_reg && end_reg, last_reg)

endmodule

>>> src/json_path_record_escaper_core.sv
// An accepted byte passes the sequencer's input register, then the result register.
// Throughput: one input beat per cycle for beats that yield a single output byte; a
// longer beat holds busy until the one-byte-per-cycle sequencer reaches its last byte.
// Results are strobed for one cycle each and the receiver cannot stall.
// Reset (rst_n low, asynchronous) clears both config registers to 0 and empties the pipeline.
module json_path_record_escaper_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] path_byte,
    input  logic       first_of_path,
    input  logic       last_of_path,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic       cfg_data,
    output logic       out_strobe,
    output logic [7:0] out_byte,
    output logic       record_end,
    output logic       run_last
);
    import jpre_pkg::*;

    jpre_cfg_t  cfg;
    jpre_slot_t slot;

    // Configuration registers.
    jpre_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Input register and output position counter.
    jpre_sequencer u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .path_byte     (path_byte),
        .first_of_path (first_of_path),
        .last_of_path  (last_of_path),
        .cfg           (cfg),
        .slot          (slot)
    );

    // Byte selection and result register.
    jpre_byte_gen u_gen (
        .clk        (clk),
        .rst_n      (rst_n),
        .slot       (slot),
        .out_strobe (out_strobe),
        .out_byte   (out_byte),
        .record_end (record_end),
        .run_last   (run_last)
    );

endmodule
